@@ rtl/core/mpfe_pkg.sv @@
`timescale 1ns / 1ps
// shared constants and types of the monochrome page frame buffer engine
package mpfe_pkg;

   localparam int COLUMNS_DEF = 128;
   localparam int PAGES_DEF   = 8;
   localparam int BYTE_W      = 8;
   localparam int COORD_W     = 8;
   localparam int KIND_W      = 2;
   localparam int HEADER_LEN  = 3;

   // position of each command byte inside a page header
   localparam int SLOT_PAGE     = 0;
   localparam int SLOT_COL_LOW  = 1;
   localparam int SLOT_COL_HIGH = 2;

   localparam logic [BYTE_W-1:0] CMD_PAGE_BASE = 8'hB0;
   localparam logic [BYTE_W-1:0] CMD_COL_LOW   = 8'h00;
   localparam logic [BYTE_W-1:0] CMD_COL_HIGH  = 8'h10;

   typedef enum logic [KIND_W-1:0] {
      KIND_PLOT    = 2'd0,
      KIND_FILL    = 2'd1,
      KIND_REFRESH = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FILL,
      ST_REF_READ,
      ST_REF_OUT
   } state_type;

endpackage

@@ rtl/core/mpfe_if.sv @@
`timescale 1ns / 1ps
// request and response channel interfaces of the frame buffer engine
interface mpfe_req_if;
   logic                         valid;
   logic                         ready;
   logic [mpfe_pkg::KIND_W-1:0]  kind;
   logic [mpfe_pkg::COORD_W-1:0] x_first;
   logic [mpfe_pkg::COORD_W-1:0] y_first;
   logic [mpfe_pkg::COORD_W-1:0] x_last;
   logic [mpfe_pkg::COORD_W-1:0] y_last;
   logic                         paint;

   modport source (output valid, kind, x_first, y_first, x_last, y_last, paint,
                   input ready);
   modport sink   (input valid, kind, x_first, y_first, x_last, y_last, paint,
                   output ready);
endinterface

interface mpfe_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [mpfe_pkg::BYTE_W-1:0] out_byte;
   logic                        is_data;
   logic                        frame_end;

   modport source (output valid, out_byte, is_data, frame_end, input ready);
   modport sink   (input valid, out_byte, is_data, frame_end, output ready);
endinterface

@@ rtl/core/mpfe_frame_mem.sv @@
`timescale 1ns / 1ps
// single write, single read frame memory with registered read data
module mpfe_frame_mem #(
   parameter int DEPTH  = mpfe_pkg::COLUMNS_DEF * mpfe_pkg::PAGES_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [mpfe_pkg::BYTE_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [mpfe_pkg::BYTE_W-1:0] rd_data
);
   import mpfe_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/mono_page_framebuffer_engine_unit.sv @@
`timescale 1ns / 1ps
// monochrome page frame buffer engine: pixel plot, rectangle fill, panel refresh stream
//
//   channel   dir   handshake      payload
//   req_bus   in    valid/ready    kind, x_first, y_first, x_last, y_last, paint
//   rsp_bus   out   valid/ready    out_byte, is_data, frame_end
//
// a plot touches one byte, a fill each byte of its columns x pages: one frame memory
// byte is read and written back per cycle through the single read and write port
// a refresh tick steps through accept, memory read and load of the output register
// after reset a clearing pass writes COLUMNS*PAGES zero bytes (1024 by default) before
// any request is taken; a held output register stalls the next tick and later requests
module mono_page_framebuffer_engine_unit #(
   parameter int COLUMNS = mpfe_pkg::COLUMNS_DEF,
   parameter int PAGES   = mpfe_pkg::PAGES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   mpfe_req_if.sink   req_bus,
   mpfe_rsp_if.source rsp_bus
);
   import mpfe_pkg::*;

   localparam int DEPTH  = COLUMNS * PAGES;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int ROW_W  = PAGE_W + 3;
   localparam int SLOT_W = $clog2(COLUMNS + HEADER_LEN);
   localparam logic [COORD_W:0]   COL_MAX   = (COORD_W + 1)'(COLUMNS - 1);
   localparam logic [COORD_W:0]   ROW_MAX   = (COORD_W + 1)'(PAGES * 8 - 1);
   localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(COLUMNS + HEADER_LEN - 1);
   localparam logic [SLOT_W-1:0]  SLOT_HDR  = SLOT_W'(HEADER_LEN);
   localparam logic [ADDR_W-1:0]  ADDR_LAST = ADDR_W'(DEPTH - 1);
   localparam logic [ADDR_W-1:0]  ADDR_PGS  = ADDR_W'(PAGES);
   localparam logic [PAGE_W-1:0]  PAGE_LAST = PAGE_W'(PAGES - 1);
   localparam logic [COL_W-1:0]   COL_LAST  = COL_W'(COLUMNS - 1);

   state_type state_ff, state_in;

   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [COL_W-1:0]  cx_ff, cx_in, xend_ff, xend_in;
   logic [PAGE_W-1:0] grp_ff, grp_in, gstart_ff, gstart_in, gend_ff, gend_in;
   logic [ROW_W-1:0]  ylo_ff, ylo_in, yhi_ff, yhi_in;
   logic              paint_ff, paint_in;
   logic              wb_valid_ff, wb_valid_in;
   logic [ADDR_W-1:0] wb_addr_ff, wb_addr_in;
   logic [BYTE_W-1:0] wb_mask_ff, wb_mask_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_data_ff, rsp_data_in;
   logic              rsp_end_ff, rsp_end_in;

   // request decode
   logic             req_ready, req_fire;
   logic             is_plot, is_fill, is_refresh;
   logic [COORD_W-1:0] x_hi_raw, y_hi_raw;
   logic [COORD_W:0] x_hi_clip, y_hi_clip;
   logic             rect_ok, draw_start;

   // fill walk
   logic [PAGE_W-1:0] fill_page;
   logic [ADDR_W-1:0] fill_addr;
   logic [BYTE_W-1:0] fill_mask;
   logic [ROW_W-1:0]  bit_row [BYTE_W];
   logic              grp_last, fill_last, clr_last;

   // refresh
   logic              ref_is_data;
   logic [COL_W-1:0]  ref_col;
   logic [ADDR_W-1:0] ref_addr;
   logic              out_load;

   // memory port
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [BYTE_W-1:0] mem_wdata, mem_rdata;

   mpfe_frame_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_frame_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign req_fire = req_bus.valid & req_ready;

   always_comb begin
      is_plot    = 1'b0;
      is_fill    = 1'b0;
      is_refresh = 1'b0;
      unique case (kind_type'(req_bus.kind))
         KIND_PLOT:    is_plot    = 1'b1;
         KIND_FILL:    is_fill    = 1'b1;
         KIND_REFRESH: is_refresh = 1'b1;
         default:      ;
      endcase
   end

   // a plot is a one pixel rectangle
   assign x_hi_raw  = is_plot ? req_bus.x_first : req_bus.x_last;
   assign y_hi_raw  = is_plot ? req_bus.y_first : req_bus.y_last;
   assign x_hi_clip = ({1'b0, x_hi_raw} > COL_MAX) ? COL_MAX : {1'b0, x_hi_raw};
   assign y_hi_clip = ({1'b0, y_hi_raw} > ROW_MAX) ? ROW_MAX : {1'b0, y_hi_raw};
   assign rect_ok   = (req_bus.x_first <= x_hi_raw) && (req_bus.y_first <= y_hi_raw) &&
                      ({1'b0, req_bus.x_first} <= COL_MAX) &&
                      ({1'b0, req_bus.y_first} <= ROW_MAX);
   assign draw_start = req_fire && (is_plot || is_fill) && rect_ok;

   // rows are flipped: row group g lives in page PAGES-1-g, row 8g+r at bit 7-r
   assign fill_page = PAGE_LAST - grp_ff;
   assign fill_addr = ADDR_W'(cx_ff) * ADDR_PGS + ADDR_W'(fill_page);

   always_comb begin
      for (int b = 0; b < BYTE_W; b++) begin
         bit_row[b]   = {grp_ff, 3'(7 - b)};
         fill_mask[b] = (bit_row[b] >= ylo_ff) && (bit_row[b] <= yhi_ff);
      end
   end

   assign grp_last  = (grp_ff == gend_ff);
   assign fill_last = grp_last && (cx_ff == xend_ff);
   assign clr_last  = (clr_addr_ff == ADDR_LAST);

   assign ref_is_data = (slot_ff >= SLOT_HDR);
   assign ref_col     = ref_is_data ? COL_W'(slot_ff - SLOT_HDR) : '0;
   assign ref_addr    = ADDR_W'(ref_col) * ADDR_PGS + ADDR_W'(page_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (draw_start) state_in = ST_FILL;
            else if (req_fire && is_refresh) state_in = ST_REF_READ;
         end
         ST_FILL: begin
            if (fill_last) state_in = ST_IDLE;
         end
         ST_REF_READ: begin
            state_in = ST_REF_OUT;
         end
         ST_REF_OUT: begin
            if (out_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state machine outputs
   always_comb begin
      req_ready = 1'b0;
      out_load  = 1'b0;
      mem_raddr = ref_addr;
      mem_we    = wb_valid_ff;
      mem_waddr = wb_addr_ff;
      mem_wdata = paint_ff ? (mem_rdata | wb_mask_ff) : (mem_rdata & ~wb_mask_ff);
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
            mem_wdata = '0;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_FILL: begin
            mem_raddr = fill_addr;
         end
         ST_REF_OUT: begin
            out_load = !rsp_valid_ff || rsp_bus.ready;
         end
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      clr_addr_in  = clr_addr_ff;
      cx_in        = cx_ff;
      xend_in      = xend_ff;
      grp_in       = grp_ff;
      gstart_in    = gstart_ff;
      gend_in      = gend_ff;
      ylo_in       = ylo_ff;
      yhi_in       = yhi_ff;
      paint_in     = paint_ff;
      slot_in      = slot_ff;
      page_in      = page_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;

      // one byte in flight between read and write back
      wb_valid_in = (state_ff == ST_FILL);
      wb_addr_in  = fill_addr;
      wb_mask_in  = fill_mask;

      if (state_ff == ST_CLEAR) begin
         clr_addr_in = clr_addr_ff + 1'b1;
      end

      if (draw_start) begin
         cx_in     = req_bus.x_first[COL_W-1:0];
         xend_in   = x_hi_clip[COL_W-1:0];
         ylo_in    = req_bus.y_first[ROW_W-1:0];
         yhi_in    = y_hi_clip[ROW_W-1:0];
         grp_in    = req_bus.y_first[ROW_W-1:3];
         gstart_in = req_bus.y_first[ROW_W-1:3];
         gend_in   = y_hi_clip[ROW_W-1:3];
         paint_in  = req_bus.paint;
      end else if (state_ff == ST_FILL) begin
         if (grp_last) begin
            grp_in = gstart_ff;
            cx_in  = cx_ff + 1'b1;
         end else begin
            grp_in = grp_ff + 1'b1;
         end
      end

      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = ref_is_data;
         rsp_end_in   = ref_is_data && (ref_col == COL_LAST) && (page_ff == PAGE_LAST);
         if (slot_ff == SLOT_W'(SLOT_PAGE)) begin
            rsp_byte_in = CMD_PAGE_BASE + BYTE_W'(page_ff);
         end else if (slot_ff == SLOT_W'(SLOT_COL_LOW)) begin
            rsp_byte_in = CMD_COL_LOW;
         end else if (slot_ff == SLOT_W'(SLOT_COL_HIGH)) begin
            rsp_byte_in = CMD_COL_HIGH;
         end else begin
            rsp_byte_in = mem_rdata;
         end

         if (slot_ff == SLOT_LAST) begin
            slot_in = '0;
            page_in = (page_ff == PAGE_LAST) ? '0 : page_ff + 1'b1;
         end else begin
            slot_in = slot_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         wb_valid_ff  <= 1'b0;
         slot_ff      <= '0;
         page_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         wb_valid_ff  <= wb_valid_in;
         slot_ff      <= slot_in;
         page_ff      <= page_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff       <= cx_in;
      xend_ff     <= xend_in;
      grp_ff      <= grp_in;
      gstart_ff   <= gstart_in;
      gend_ff     <= gend_in;
      ylo_ff      <= ylo_in;
      yhi_ff      <= yhi_in;
      paint_ff    <= paint_in;
      wb_addr_ff  <= wb_addr_in;
      wb_mask_ff  <= wb_mask_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_data_ff <= rsp_data_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign req_bus.ready     = req_ready;
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_byte  = rsp_byte_ff;
   assign rsp_bus.is_data   = rsp_data_ff;
   assign rsp_bus.frame_end = rsp_end_ff;

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the monochrome page frame buffer engine
module tb_top;
   import mpfe_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int COLS         = COLUMNS_DEF;
   localparam int PAGE_COUNT   = PAGES_DEF;
   localparam int ROWS         = PAGE_COUNT * 8;
   localparam int SCAN_LEN     = HEADER_LEN + COLS;
   localparam int RANDOM_ITEMS = 1800;
   localparam int DRAIN_CYCLES = 1200;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int MAX_GAP      = 12;
   localparam int DIRECTED_N   = 25;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              is_data;
      logic              frame_end;
   } panel_byte_t;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [COORD_W-1:0] x_first;
      logic [COORD_W-1:0] y_first;
      logic [COORD_W-1:0] x_last;
      logic [COORD_W-1:0] y_last;
      logic               paint;
      logic               fixed;      // expected byte typed in below
      panel_byte_t        fixed_rsp;
   } request_t;

   localparam panel_byte_t NO_RSP = '{8'h00, 1'b0, 1'b0};

   logic clock = 1'b0;
   logic reset = 1'b1;

   mpfe_req_if req_bus ();
   mpfe_rsp_if rsp_bus ();

   mono_page_framebuffer_engine_unit u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // shadow copy of the frame memory and the refresh position
   logic [BYTE_W-1:0] shadow_fb [COLS*PAGE_COUNT];
   int                scan_page;
   int                scan_slot;

   panel_byte_t expected_bytes [$];
   int          fail_count = 0;
   int          cycle_count = 0;
   bit          req_quiet = 1'b0;
   bit          rsp_quiet = 1'b0;

   // directed table: after reset the stream and the cleared buffer are known
   request_t directed_rows [DIRECTED_N] = '{
      '{KIND_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, '{CMD_PAGE_BASE, 1'b0, 1'b0}},
      '{KIND_REFRESH, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1,
        '{CMD_COL_LOW, 1'b0, 1'b0}},
      '{KIND_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, '{CMD_COL_HIGH, 1'b0, 1'b0}},
      '{KIND_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0}},
      '{KIND_PLOT,    8'd1, 8'd63, 8'd0, 8'd0, 1'b1, 1'b0, NO_RSP},
      '{KIND_PLOT,    8'd1, 8'd56, 8'd255, 8'd255, 1'b1, 1'b0, NO_RSP},
      '{KIND_PLOT,    8'd128, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, NO_RSP},
      '{KIND_PLOT,    8'd0, 8'd64, 8'd0, 8'd0, 1'b1, 1'b0, NO_RSP},
      '{KIND_PLOT,    8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0, NO_RSP},
      '{KIND_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_RSP},
      '{KIND_FILL,    8'd10, 8'd0, 8'd5, 8'd63, 1'b1, 1'b0, NO_RSP},
      '{KIND_FILL,    8'd0, 8'd10, 8'd127, 8'd9, 1'b1, 1'b0, NO_RSP},
      '{KIND_FILL,    8'd2, 8'd0, 8'd255, 8'd255, 1'b1, 1'b0, NO_RSP},
      '{KIND_FILL,    8'd0, 8'd8, 8'd127, 8'd15, 1'b0, 1'b0, NO_RSP},
      '{KIND_UNUSED,  8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0, NO_RSP},
      '{KIND_PLOT,    8'd2, 8'd63, 8'd0, 8'd0, 1'b0, 1'b0, NO_RSP},
      '{KIND_PLOT,    8'd127, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, NO_RSP},
      '{KIND_PLOT,    8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, NO_RSP},
      '{KIND_FILL,    8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_RSP},
      '{KIND_FILL,    8'd0, 8'd0, 8'd255, 8'd255, 1'b1, 1'b0, NO_RSP},
      '{KIND_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_RSP},
      '{KIND_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_RSP},
      '{KIND_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_RSP},
      '{KIND_FILL,    8'd0, 8'd0, 8'd127, 8'd63, 1'b0, 1'b0, NO_RSP},
      '{KIND_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_RSP}
   };

   // rows are flipped: row y sits in page PAGES-1-y/8, bit 7-y%8
   function automatic void draw_pixel(int x, int y, logic paint);
      int                idx;
      logic [BYTE_W-1:0] mask;
      if (x >= COLS || y >= ROWS) return;
      idx  = x * PAGE_COUNT + (PAGE_COUNT - 1 - y / 8);
      mask = 8'h80 >> (y % 8);
      if (paint) shadow_fb[idx] = shadow_fb[idx] | mask;
      else shadow_fb[idx] = shadow_fb[idx] & ~mask;
   endfunction

   function automatic void fill_area(int x1, int y1, int x2, int y2, logic paint);
      if (x1 > x2 || y1 > y2) return;
      if (x2 > COLS - 1) x2 = COLS - 1;
      if (y2 > ROWS - 1) y2 = ROWS - 1;
      for (int x = x1; x <= x2; x++)
         for (int y = y1; y <= y2; y++)
            draw_pixel(x, y, paint);
   endfunction

   function automatic panel_byte_t next_panel_byte();
      panel_byte_t b;
      int          col;
      b = NO_RSP;
      if (scan_slot == SLOT_PAGE) begin
         b.out_byte = CMD_PAGE_BASE + BYTE_W'(scan_page);
      end else if (scan_slot == SLOT_COL_LOW) begin
         b.out_byte = CMD_COL_LOW;
      end else if (scan_slot == SLOT_COL_HIGH) begin
         b.out_byte = CMD_COL_HIGH;
      end else begin
         col         = scan_slot - HEADER_LEN;
         b.out_byte  = shadow_fb[col * PAGE_COUNT + scan_page];
         b.is_data   = 1'b1;
         b.frame_end = (col == COLS - 1) && (scan_page == PAGE_COUNT - 1);
      end
      scan_slot++;
      if (scan_slot >= SCAN_LEN) begin
         scan_slot = 0;
         scan_page = (scan_page + 1) % PAGE_COUNT;
      end
      return b;
   endfunction

   function automatic void apply_request(request_t r);
      case (r.kind)
         KIND_PLOT:    draw_pixel(r.x_first, r.y_first, r.paint);
         KIND_FILL:    fill_area(r.x_first, r.y_first, r.x_last, r.y_last, r.paint);
         KIND_REFRESH: expected_bytes.push_back(next_panel_byte());
         default: ;
      endcase
   endfunction

   function automatic request_t random_request();
      request_t r;
      int       roll, xf, yf, xl, yl, tmp;
      r.kind    = KIND_REFRESH;
      r.x_first = COORD_W'($urandom_range(0, 255));
      r.y_first = COORD_W'($urandom_range(0, 255));
      r.x_last  = COORD_W'($urandom_range(0, 255));
      r.y_last  = COORD_W'($urandom_range(0, 255));
      r.paint   = 1'($urandom_range(0, 1));
      r.fixed   = 1'b0;
      r.fixed_rsp = NO_RSP;
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
         r.kind = KIND_REFRESH;
      end else if (roll < 82) begin
         r.kind = KIND_PLOT;
         if ($urandom_range(0, 6) != 0) begin
            r.x_first = COORD_W'($urandom_range(0, COLS - 1));
            r.y_first = COORD_W'($urandom_range(0, ROWS - 1));
         end
      end else if (roll < 97) begin
         r.kind = KIND_FILL;
         if ($urandom_range(0, 24) == 0) begin
            // near full screen, walks most of the memory
            xf = $urandom_range(0, 20);
            xl = $urandom_range(100, 255);
            yf = $urandom_range(0, 8);
            yl = $urandom_range(40, 255);
         end else begin
            xf = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 127);
            yf = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 63);
            xl = xf + $urandom_range(0, 15);
            yl = yf + $urandom_range(0, 12);
            if (xl > 255) xl = 255;
            if (yl > 255) yl = 255;
            // reversed corners now and then
            if ($urandom_range(0, 9) == 0) begin
               tmp = xf; xf = xl; xl = tmp;
            end
            if ($urandom_range(0, 9) == 0) begin
               tmp = yf; yf = yl; yl = tmp;
            end
         end
         r.x_first = COORD_W'(xf);
         r.y_first = COORD_W'(yf);
         r.x_last  = COORD_W'(xl);
         r.y_last  = COORD_W'(yl);
      end else begin
         r.kind = KIND_UNUSED;
      end
      return r;
   endfunction

   // valid stays high into the next item when no gap is drawn
   task automatic send_item(request_t r);
      int gap;
      if ($urandom_range(0, 59) == 0) req_quiet = !req_quiet;
      gap = req_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.kind    <= r.kind;
      req_bus.x_first <= r.x_first;
      req_bus.y_first <= r.y_first;
      req_bus.x_last  <= r.x_last;
      req_bus.y_last  <= r.y_last;
      req_bus.paint   <= r.paint;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      apply_request(r);
      if (r.fixed) expected_bytes[$] = r.fixed_rsp;
   endtask

   // always lets at least one edge pass so valid is driven once per time step
   task automatic hold_until_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_bytes.size() != 0);
   endtask

   task automatic check_panel_byte(panel_byte_t got);
      panel_byte_t want;
      if (expected_bytes.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("unexpected transfer: byte %h data %b end %b",
                     got.out_byte, got.is_data, got.frame_end);
         return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte || got.is_data !== want.is_data ||
          got.frame_end !== want.frame_end) begin
         fail_count++;
         if (fail_count <= 10)
            $display("mismatch: byte %h/%h data %b/%b end %b/%b (expected/actual)",
                     want.out_byte, got.out_byte, want.is_data, got.is_data,
                     want.frame_end, got.frame_end);
      end
   endtask

   // response side: random stalls before each transfer
   initial begin : rsp_side
      int          stall;
      panel_byte_t got;
      rsp_bus.ready = 1'b0;
      forever begin
         if ($urandom_range(0, 59) == 0) rsp_quiet = !rsp_quiet;
         stall = rsp_quiet ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         got.out_byte  = rsp_bus.out_byte;
         got.is_data   = rsp_bus.is_data;
         got.frame_end = rsp_bus.frame_end;
         check_panel_byte(got);
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      request_t item;
      int       n_sent;
      bit       paused;
      req_bus.valid   = 1'b0;
      req_bus.kind    = KIND_PLOT;
      req_bus.x_first = '0;
      req_bus.y_first = '0;
      req_bus.x_last  = '0;
      req_bus.y_last  = '0;
      req_bus.paint   = 1'b0;
      foreach (shadow_fb[i]) shadow_fb[i] = '0;
      scan_page = 0;
      scan_slot = 0;
      n_sent    = 0;
      paused    = 1'b0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_item(directed_rows[i]);
      hold_until_drained();

      while (n_sent < RANDOM_ITEMS) begin
         if (!paused && n_sent == RANDOM_ITEMS / 2) begin
            hold_until_drained();
            paused = 1'b1;
         end
         item = random_request();
         send_item(item);
         if (item.kind != KIND_UNUSED) n_sent++;
      end
      req_bus.valid <= 1'b0;

      while (expected_bytes.size() != 0) @(posedge clock);
      // a trailing fill may still be running; catch any stray transfer
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && expected_bytes.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/mpfe_pkg.sv
rtl/core/mpfe_if.sv
rtl/core/mpfe_frame_mem.sv
rtl/core/mono_page_framebuffer_engine_unit.sv
dv/tb_top.sv
